>>> src/srcp_pkg.sv
// ----------------------------------------------------------------------------
// srcp_pkg
// shared types and constants of the reply code parser
// ----------------------------------------------------------------------------
package srcp_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_CLASS     = 2'd2,
		ST_IO        = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  code;
	} result_t;

	localparam logic [7:0] ASCII_NL    = 8'h0A;
	localparam logic [7:0] ASCII_DASH  = 8'h2D;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;

	localparam logic [3:0] CLASS_RESET = 4'd2;
	localparam int unsigned CODE_MAX   = 999;

endpackage

>>> src/smtp_reply_code_parser_top.sv
// ----------------------------------------------------------------------------
// smtp_reply_code_parser_top
// splits reply bytes into lines and reports the final code of each reply
// ----------------------------------------------------------------------------
// path: the item that ends the reply passes the input register, then the result register
// throughput: one item per cycle while the result is not stalled, set by the line state update
// a held result lets an empty input register take one more item, then in_stall rises
// reset: arst_n asynchronous, clears line state, empties both registers
// and sets the class register to 2; no clearing pass
module smtp_reply_code_parser_top import srcp_pkg::*; #(
	parameter int unsigned LINE_LIMIT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	// byte channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       read_failed,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [9:0] reply_code,
	// config write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	logic       adv;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fail_s1;
	logic [3:0] class_q;
	result_t    res_q;

	// config is to be written only while idle (not enforced here), so it can always be taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= CLASS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			class_q <= cfg_data;
		end
	end

	// byte register in front of the parser
	srcp_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.read_failed (read_failed),
		.adv         (adv),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.fail_s1     (fail_s1)
	);

	// line tracking and the result register
	srcp_parse #(
		.LINE_LIMIT (LINE_LIMIT)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.byte_s1        (byte_s1),
		.fail_s1        (fail_s1),
		.good_class     (class_q),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.res_q          (res_q)
	);

	// unpack the result item onto its field ports
	assign status     = res_q.status;
	assign reply_code = res_q.code;

endmodule

>>> src/srcp_in_stage.sv
// ----------------------------------------------------------------------------
// srcp_in_stage
// input register for one received byte or read failure
// ----------------------------------------------------------------------------
module srcp_in_stage import srcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       read_failed,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       fail_s1
);

	// only a held item that cannot move on blocks the input
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			fail_s1 <= read_failed;
		end
	end

endmodule

>>> src/srcp_parse.sv
// ----------------------------------------------------------------------------
// srcp_parse
// line state, end-of-line decision and result register
// ----------------------------------------------------------------------------
module srcp_parse import srcp_pkg::*; #(
	parameter int unsigned LINE_LIMIT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  logic [7:0] byte_s1,
	input  logic       fail_s1,
	input  logic [3:0] good_class,
	output logic       adv,
	output logic       out_valid,
	input  logic       out_stall,
	output result_t    res_q
);

	localparam int unsigned PosW = $clog2(LINE_LIMIT);
	localparam logic [PosW-1:0] LastPos = PosW'(LINE_LIMIT - 1);
	localparam logic [PosW-1:0] Pos3    = PosW'(3);
	localparam logic [PosW-1:0] Pos4    = PosW'(4);

	logic [PosW-1:0] pos_q;
	logic [9:0]      acc_q;
	logic [3:0]      hund_q;
	logic            digits_ok_q;
	logic            dash_q;

	logic [PosW-1:0] pos_next;
	logic [3:0]      digit;
	logic            is_digit;
	logic            line_end;
	logic            emit;
	logic            clear;
	logic [9:0]      acc_next;
	logic            digits_next;
	result_t         res_next;

	assign adv = !out_valid || !out_stall;

	assign digit    = byte_s1[3:0];
	assign is_digit = (byte_s1 >= ASCII_ZERO) && (byte_s1 <= ASCII_NINE);
	assign pos_next = pos_q + PosW'(1);
	assign line_end = (byte_s1 == ASCII_NL) || (pos_next >= LastPos);
	assign acc_next = (acc_q << 3) + (acc_q << 1) + {6'd0, digit};
	assign digits_next = digits_ok_q && ((pos_q >= Pos3) || is_digit);

	always_comb begin
		emit     = 1'b0;
		clear    = 1'b0;
		res_next = '{status: ST_OK, code: 10'd0};
		priority if (fail_s1) begin
			emit = 1'b1;
			res_next.status = ST_IO;
		end else if (line_end) begin
			clear = 1'b1;
			priority if (pos_next < Pos4 || !digits_next) begin
				emit = 1'b1;
				res_next.status = ST_MALFORMED;
			end else if (dash_q || (pos_q == Pos3 && byte_s1 == ASCII_DASH)) begin
				emit = 1'b0;
			end else begin
				emit = 1'b1;
				res_next.code   = acc_q;
				res_next.status = (hund_q == good_class) ? ST_OK : ST_CLASS;
			end
		end else begin
			// byte inside a line, nothing to report
			emit = 1'b0;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			acc_q       <= '0;
			hund_q      <= '0;
			digits_ok_q <= 1'b1;
			dash_q      <= 1'b0;
		end else if (adv && valid_s1) begin
			if (fail_s1 || clear) begin
				pos_q       <= '0;
				acc_q       <= '0;
				hund_q      <= '0;
				digits_ok_q <= 1'b1;
				dash_q      <= 1'b0;
			end else begin
				pos_q       <= pos_next;
				digits_ok_q <= digits_next;
				if (pos_q < Pos3 && is_digit) begin
					acc_q <= acc_next;
				end
				if (pos_q == '0) begin
					hund_q <= digit;
				end
				if (pos_q == Pos3) begin
					dash_q <= (byte_s1 == ASCII_DASH);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			res_q <= res_next;
		end
	end

endmodule

>>> src/srcp_checker.sv
// ----------------------------------------------------------------------------
// srcp_checker
// port level checks of the reply code parser
// ----------------------------------------------------------------------------
module srcp_checker import srcp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [9:0] reply_code
);

	// a held result keeps its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(reply_code))
		else $error("result changed while stalled");

	// input only backs up behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// malformed line and read failure carry no code
	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_MALFORMED || status == ST_IO) |-> reply_code == 10'd0)
		else $error("nonzero code on error result");

	// a code has three decimal digits
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reply_code <= 10'(CODE_MAX))
		else $error("reply code out of range");

endmodule

bind smtp_reply_code_parser_top srcp_checker u_srcp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.reply_code (reply_code)
);
